### hdl/http_request_header_parser_assert.svh
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HRHP_ASSERT(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
else $error("parser assertion failed");
`define HRHP_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("parser assertion failed");
`else
`define HRHP_ASSERT(lbl, cond)
`define HRHP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### hdl/hrhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, result kinds and constant string lookups for the request parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam logic [2:0] KIND_METHOD   = 3'd0;
	localparam logic [2:0] KIND_URL      = 3'd1;
	localparam logic [2:0] KIND_PROTO    = 3'd2;
	localparam logic [2:0] KIND_HEADER   = 3'd3;
	localparam logic [2:0] KIND_COOKIE   = 3'd4;
	localparam logic [2:0] KIND_HDR_DONE = 3'd5;
	localparam logic [2:0] KIND_MSG_DONE = 3'd6;
	localparam logic [2:0] KIND_ERROR    = 3'd7;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned LEN_CLEN   = 14;
	localparam int unsigned LEN_COOKIE = 6;

	// one result entry
	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] name_off;
		logic [13:0] name_len;
		logic [12:0] val_off;
		logic [13:0] val_len;
		logic [31:0] body_len;
		logic        last;
	} res_t;

	function automatic res_t mk_res(input logic [2:0] kind, input logic [12:0] no,
			input logic [13:0] nl, input logic [12:0] vo, input logic [13:0] vl,
			input logic [31:0] bl);
		res_t r;
		r.kind = kind;
		r.name_off = no;
		r.name_len = nl;
		r.val_off = vo;
		r.val_len = vl;
		r.body_len = bl;
		r.last = 1'b0;
		return r;
	endfunction

	// "Content-Length"
	function automatic logic [7:0] clen_char(input logic [3:0] i);
		logic [7:0] c;
		unique case (i)
			4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
			4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
			4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
			4'd12: c = "t"; 4'd13: c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "Cookie"
	function automatic logic [7:0] cookie_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = "C"; 3'd1: c = "o"; 3'd2: c = "o";
			3'd3: c = "k"; 3'd4: c = "i"; 3'd5: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// bodyless methods: 0 HEAD, 1 GET, 2 OPTIONS, 3 TRACE
	function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (m)
			2'd0: unique case (i)
				3'd0: c = "H"; 3'd1: c = "E"; 3'd2: c = "A"; 3'd3: c = "D";
				default: c = 8'h00;
			endcase
			2'd1: unique case (i)
				3'd0: c = "G"; 3'd1: c = "E"; 3'd2: c = "T";
				default: c = 8'h00;
			endcase
			2'd2: unique case (i)
				3'd0: c = "O"; 3'd1: c = "P"; 3'd2: c = "T"; 3'd3: c = "I";
				3'd4: c = "O"; 3'd5: c = "N"; 3'd6: c = "S";
				default: c = 8'h00;
			endcase
			default: unique case (i)
				3'd0: c = "T"; 3'd1: c = "R"; 3'd2: c = "A"; 3'd3: c = "C";
				3'd4: c = "E";
				default: c = 8'h00;
			endcase
		endcase
		return c;
	endfunction

	function automatic logic [2:0] meth_len(input logic [1:0] m);
		logic [2:0] l;
		unique case (m)
			2'd0: l = 3'd4;
			2'd1: l = 3'd3;
			2'd2: l = 3'd7;
			default: l = 3'd5;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

### hdl/hrhp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_core
// Parse state and per-byte parse logic; emits up to two results per byte.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_assert.svh"
module hrhp_core
	import hrhp_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 8192
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       acc,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_new,
	output logic [1:0]      res_n,
	output res_t            res0,
	output res_t            res1
);

	localparam int unsigned PW = $clog2(HEADER_BYTES) + 1;
	localparam logic [PW-1:0] POS_LIMIT = PW'(HEADER_BYTES - 1);

	localparam logic [3:0] PH_WAIT   = 4'd0;
	localparam logic [3:0] PH_METHOD = 4'd1;
	localparam logic [3:0] PH_URL    = 4'd2;
	localparam logic [3:0] PH_PROTO  = 4'd3;
	localparam logic [3:0] PH_LINE   = 4'd4;
	localparam logic [3:0] PH_NAME   = 4'd5;
	localparam logic [3:0] PH_SKIP   = 4'd6;
	localparam logic [3:0] PH_VALUE  = 4'd7;
	localparam logic [3:0] PH_CR     = 4'd8;
	localparam logic [3:0] PH_BODY   = 4'd9;
	localparam logic [3:0] PH_DONE   = 4'd10;
	localparam logic [3:0] PH_ERROR  = 4'd11;

	logic [3:0]    phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d, fstart_q, fstart_d, fcount_q, fcount_d;
	logic [PW-1:0] hoff_q, hoff_d, hlen_q, hlen_d;
	logic [1:0]    nmf_q, nmf_d;
	logic [3:0]    mmf_q, mmf_d;
	logic [31:0]   clen_q, clen_d, bcount_q, bcount_d;
	logic          lgiven_q, lgiven_d;
	logic [1:0]    lend_q, lend_d;
	logic          ctok_q, ctok_d, cin_q, cin_d;
	logic [PW-1:0] ccur_q, ccur_d, cnoff_q, cnoff_d, cnlen_q, cnlen_d;
	logic [PW-1:0] cvoff_q, cvoff_d, cvlen_q, cvlen_d;

	res_t       r [2];
	logic [1:0] n;

	// per-byte parse step
	always_comb begin
		logic [35:0]  v;
		logic         fail;
		logic         pair;
		logic         do_close;
		logic         hdone;
		logic         bodyless;
		logic [31:0]  bl;
		phase_d = phase_q; pos_d = pos_q; fstart_d = fstart_q; fcount_d = fcount_q;
		hoff_d = hoff_q; hlen_d = hlen_q; nmf_d = nmf_q; mmf_d = mmf_q;
		clen_d = clen_q; bcount_d = bcount_q; lgiven_d = lgiven_q; lend_d = lend_q;
		ctok_d = ctok_q; cin_d = cin_q; ccur_d = ccur_q; cnoff_d = cnoff_q;
		cnlen_d = cnlen_q; cvoff_d = cvoff_q; cvlen_d = cvlen_q;
		r[0] = '0; r[1] = '0; n = 2'd0;
		v = '0; fail = 1'b0; pair = 1'b0; do_close = 1'b0; hdone = 1'b0;
		bodyless = 1'b0; bl = '0;

		if (start_new) begin
			phase_d = PH_METHOD; pos_d = '0; fstart_d = '0; fcount_d = '0;
			hoff_d = '0; hlen_d = '0; nmf_d = 2'b11; mmf_d = 4'hF;
			clen_d = '0; bcount_d = '0; lgiven_d = 1'b0; lend_d = '0;
			ctok_d = 1'b0; cin_d = 1'b1; ccur_d = '0; cnoff_d = '0;
			cnlen_d = '0; cvoff_d = '0; cvlen_d = '0;
		end

		if (phase_d == PH_WAIT || phase_d == PH_DONE || phase_d == PH_ERROR) begin
			// idle: no result
		end else if (phase_d == PH_BODY) begin
			if (bcount_d != 32'hFFFF_FFFF) bcount_d = bcount_d + 32'd1;
			if (lgiven_d && bcount_d >= clen_d) begin
				r[0] = mk_res(KIND_MSG_DONE, '0, '0, '0, '0, clen_d);
				n = 2'd1;
				phase_d = PH_DONE;
			end
		end else begin
			if (pos_d >= POS_LIMIT) begin
				fail = 1'b1;
			end else begin
				unique case (phase_d)
					PH_METHOD: begin
						if (data_byte == CH_SP) begin
							for (int k = 0; k < 4; k++)
								if (PW'(meth_len(2'(k))) != fcount_d) mmf_d[k] = 1'b0;
							r[0] = mk_res(KIND_METHOD, 13'(fstart_d), 14'(fcount_d),
								'0, '0, '0);
							n = 2'd1;
							phase_d = PH_URL;
							fstart_d = pos_d + PW'(1);
							fcount_d = '0;
						end else if (data_byte == CH_CR || data_byte == CH_LF) begin
							fail = 1'b1;
						end else begin
							for (int k = 0; k < 4; k++)
								if (fcount_d >= PW'(meth_len(2'(k))) ||
									data_byte != meth_char(2'(k), 3'(fcount_d)))
									mmf_d[k] = 1'b0;
							fcount_d = fcount_d + PW'(1);
						end
					end
					PH_URL: begin
						if (data_byte == CH_SP) begin
							r[0] = mk_res(KIND_URL, 13'(fstart_d), 14'(fcount_d),
								'0, '0, '0);
							n = 2'd1;
							phase_d = PH_PROTO;
							fstart_d = pos_d + PW'(1);
							fcount_d = '0;
						end else if (data_byte == CH_CR || data_byte == CH_LF) begin
							fail = 1'b1;
						end else begin
							fcount_d = fcount_d + PW'(1);
						end
					end
					PH_PROTO: begin
						if (data_byte == CH_CR) begin
							r[0] = mk_res(KIND_PROTO, 13'(fstart_d), 14'(fcount_d),
								'0, '0, '0);
							n = 2'd1;
							phase_d = PH_CR;
							lend_d = 2'd1;
						end else begin
							fcount_d = fcount_d + PW'(1);
						end
					end
					PH_LINE, PH_NAME: begin
						if (phase_d == PH_LINE && data_byte == CH_CR) begin
							phase_d = PH_CR;
							lend_d = 2'd2;
						end else if (phase_d == PH_LINE && data_byte == CH_COLON) begin
							hoff_d = pos_d; hlen_d = '0;
							nmf_d = 2'b00;
							phase_d = PH_SKIP;
						end else if (phase_d == PH_NAME && data_byte == CH_COLON) begin
							if (hlen_d != PW'(LEN_CLEN)) nmf_d[0] = 1'b0;
							if (hlen_d != PW'(LEN_COOKIE)) nmf_d[1] = 1'b0;
							if (nmf_d[0]) clen_d = '0;
							ctok_d = 1'b0; cin_d = 1'b1; ccur_d = '0;
							cnoff_d = '0; cnlen_d = '0; cvoff_d = '0; cvlen_d = '0;
							phase_d = PH_SKIP;
						end else if (phase_d == PH_NAME && data_byte == CH_CR) begin
							phase_d = PH_CR;
							lend_d = 2'd1;
						end else begin
							// header name byte
							if (phase_d == PH_LINE) begin
								hoff_d = pos_d; hlen_d = '0;
								nmf_d = 2'b11;
								phase_d = PH_NAME;
							end
							if (hlen_d >= PW'(LEN_CLEN) ||
								data_byte != clen_char(4'(hlen_d)))
								nmf_d[0] = 1'b0;
							if (hlen_d >= PW'(LEN_COOKIE) ||
								data_byte != cookie_char(3'(hlen_d)))
								nmf_d[1] = 1'b0;
							hlen_d = hlen_d + PW'(1);
						end
					end
					PH_SKIP, PH_VALUE: begin
						if (phase_d == PH_SKIP &&
							(data_byte == CH_SP || data_byte == CH_TAB)) begin
							// skip blank
						end else if (data_byte == CH_CR) begin
							if (phase_d == PH_SKIP || hlen_d == '0 || fcount_d == '0) begin
								fail = 1'b1;
							end else begin
								r[0] = mk_res(KIND_HEADER, 13'(hoff_d), 14'(hlen_d),
									13'(fstart_d), 14'(fcount_d), '0);
								n = 2'd1;
								if (nmf_d[0]) lgiven_d = 1'b1;
								if (nmf_d[1]) begin
									do_close = 1'b1;
									pair = 1'b1;
								end
								phase_d = PH_CR;
								lend_d = 2'd1;
							end
						end else begin
							// value byte
							if (phase_d == PH_SKIP) begin
								fstart_d = pos_d; fcount_d = '0;
								phase_d = PH_VALUE;
							end
							fcount_d = fcount_d + PW'(1);
							if (nmf_d[0]) begin
								if (data_byte < CH_ZERO || data_byte > CH_NINE) begin
									fail = 1'b1;
								end else begin
									v = 36'(clen_d) * 36'd10 + 36'(data_byte - CH_ZERO);
									clen_d = (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
								end
							end
							if (nmf_d[1] && !fail) begin
								if (data_byte == CH_SP) begin
									do_close = 1'b1;
								end else if (data_byte == CH_EQ) begin
									do_close = 1'b1;
								end else if (data_byte == CH_SEMI) begin
									do_close = 1'b1;
									pair = 1'b1;
								end else if (!ctok_d) begin
									ccur_d = pos_d;
									ctok_d = 1'b1;
								end
							end
						end
					end
					default: begin
						// line end: LF must follow CR
						if (data_byte != CH_LF) begin
							fail = 1'b1;
						end else if (lend_d == 2'd2) begin
							hdone = 1'b1;
						end else begin
							phase_d = PH_LINE;
							lend_d = '0;
						end
					end
				endcase
			end

			// close the open cookie token at this byte
			if (do_close) begin
				if (ctok_d) begin
					if (cin_d) begin
						cnoff_d = ccur_d; cnlen_d = pos_d - ccur_d;
					end else begin
						cvoff_d = ccur_d; cvlen_d = pos_d - ccur_d;
					end
				end
				ctok_d = 1'b0;
				if (data_byte == CH_EQ && phase_d == PH_VALUE) cin_d = 1'b0;
				if (data_byte == CH_SEMI && phase_d == PH_VALUE) cin_d = 1'b1;
			end

			// emit a cookie pair when both parts are present
			if (pair && cnlen_d != '0 && cvlen_d != '0) begin
				if (n == 2'd0) begin
					r[0] = mk_res(KIND_COOKIE, 13'(cnoff_d), 14'(cnlen_d),
						13'(cvoff_d), 14'(cvlen_d), '0);
				end else begin
					r[1] = mk_res(KIND_COOKIE, 13'(cnoff_d), 14'(cnlen_d),
						13'(cvoff_d), 14'(cvlen_d), '0);
				end
				n = n + 2'd1;
				cnlen_d = '0;
				cvlen_d = '0;
			end

			// blank line closes the header
			if (hdone) begin
				bodyless = (mmf_d != 4'h0);
				bl = bodyless ? 32'd0 : clen_d;
				r[0] = mk_res(KIND_HDR_DONE, '0, '0, 13'(pos_d + PW'(1)), '0, bl);
				n = 2'd1;
				if (bodyless || (lgiven_d && clen_d == 32'd0)) begin
					r[1] = mk_res(KIND_MSG_DONE, '0, '0, '0, '0, bl);
					n = 2'd2;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_BODY;
					bcount_d = '0;
				end
			end

			if (fail) begin
				r[0] = mk_res(KIND_ERROR, '0, '0, '0, '0, '0);
				n = 2'd1;
				phase_d = PH_ERROR;
			end
			pos_d = pos_d + PW'(1);
		end

		if (n == 2'd1) r[0].last = 1'b1;
		if (n == 2'd2) r[1].last = 1'b1;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT; pos_q <= '0; fstart_q <= '0; fcount_q <= '0;
			hoff_q <= '0; hlen_q <= '0; nmf_q <= 2'b11; mmf_q <= 4'hF;
			clen_q <= '0; bcount_q <= '0; lgiven_q <= 1'b0; lend_q <= '0;
			ctok_q <= 1'b0; cin_q <= 1'b1; ccur_q <= '0; cnoff_q <= '0;
			cnlen_q <= '0; cvoff_q <= '0; cvlen_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d; pos_q <= pos_d; fstart_q <= fstart_d; fcount_q <= fcount_d;
			hoff_q <= hoff_d; hlen_q <= hlen_d; nmf_q <= nmf_d; mmf_q <= mmf_d;
			clen_q <= clen_d; bcount_q <= bcount_d; lgiven_q <= lgiven_d; lend_q <= lend_d;
			ctok_q <= ctok_d; cin_q <= cin_d; ccur_q <= ccur_d; cnoff_q <= cnoff_d;
			cnlen_q <= cnlen_d; cvoff_q <= cvoff_d; cvlen_q <= cvlen_d;
		end
	end

	assign res_n = acc ? n : 2'd0;
	assign res0 = r[0];
	assign res1 = r[1];

	// a byte giving two results never leads with an error
	`HRHP_ASSERT_IMP(a_pair_no_err, res_n == 2'd2, res0.kind != KIND_ERROR)
	// error phase is left only by a new request
	`HRHP_ASSERT_IMP(a_err_sticky, acc && phase_q == PH_ERROR && !start_new,
		phase_d == PH_ERROR && n == 2'd0)

endmodule
`default_nettype wire

### hdl/hrhp_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_resq
// Four-entry result queue: takes up to two results a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_assert.svh"
module hrhp_resq
	import hrhp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  res_t            push0,
	input  res_t            push1,
	output logic            room2,
	output logic            out_valid,
	input  wire logic       out_stall,
	output res_t            head
);

	res_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop = out_valid && !out_stall;
	assign out_valid = (count_q != 3'd0);
	assign room2 = (count_q <= 3'd2);
	assign head = mem_q[rd_q];

	// storage writes
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= push0;
		if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= push1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + push_n;
			if (pop) rd_q <= rd_q + 2'd1;
			count_q <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	`HRHP_ASSERT(a_count_max, count_q <= 3'd4)
	`HRHP_ASSERT_IMP(a_push_room, push_n != 2'd0, count_q <= 3'd2)

endmodule
`default_nettype wire

### hdl/http_request_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_header_parser
// HTTP/1.1 request parser reporting field offsets, headers and cookies.
// ----------------------------------------------------------------------------
// The parser takes one request byte per clock. Each byte is parsed in the
// cycle it is accepted and its results (at most two) are written to a
// four-entry result queue that drains one result per cycle while out_stall
// is low; the input stalls while that queue holds more than two results, so
// a byte is accepted every cycle as long as results are taken at the same
// pace. Results are registered in the queue before they appear on the output.
// No clearing pass is needed after reset.
module http_request_header_parser
	import hrhp_pkg::*;
#(
	parameter int unsigned HEADER_BYTES = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_new,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       item_kind,
	output logic [12:0]      name_offset,
	output logic [13:0]      name_length,
	output logic [12:0]      value_offset,
	output logic [13:0]      value_length,
	output logic [31:0]      content_len,
	output logic             last_item
);

	logic       acc;
	logic       room2;
	logic [1:0] res_n;
	res_t       res0, res1, head;

	assign in_stall = !room2;
	assign acc = in_valid && !in_stall;

	hrhp_core #(.HEADER_BYTES(HEADER_BYTES)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.start_new (start_new),
		.res_n     (res_n),
		.res0      (res0),
		.res1      (res1)
	);

	hrhp_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (res_n),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign item_kind    = head.kind;
	assign name_offset  = head.name_off;
	assign name_length  = head.name_len;
	assign value_offset = head.val_off;
	assign value_length = head.val_len;
	assign content_len  = head.body_len;
	assign last_item    = head.last;

endmodule
`default_nettype wire
